// ----- hw/rtl/igsfa_pkg.sv -----
`timescale 1ns / 1ps

package igsfa_pkg;

    // Store geometry
    localparam int FRAME_BYTES = 512;
    localparam int CHUNK_BYTES = 64;
    localparam int WORD_BYTES  = 8;
    localparam int WORD_ROWS   = FRAME_BYTES / WORD_BYTES;
    localparam int ROW_W       = $clog2(WORD_ROWS);
    localparam int LANE_W      = $clog2(WORD_BYTES);
    localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);

    // Field widths
    localparam int LEN_W    = 10;
    localparam int IDLE_W   = 11;
    localparam int CFG_W    = 10;
    localparam int CFG_AW   = 2;
    localparam int OUT_DW   = 128;

    // Reset values of the registers
    localparam logic [9:0] IDLE_TIMEOUT_RST = 10'd10;
    localparam logic [9:0] MAX_LENGTH_RST   = 10'd512;
    localparam logic [7:0] FRAME_TYPE_RST   = 8'h00;

    // Register indexes on the configuration port
    localparam logic [CFG_AW-1:0] REG_IDLE_TIMEOUT = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_LENGTH   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_FRAME_TYPE   = 2'd2;

    // Item kinds carried in tuser
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic read;
        logic next_word;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic close;
        logic drop;
        logic last_word;
    } t_status;

endpackage

// ----- hw/rtl/igsfa_ctrl.sv -----
`timescale 1ns / 1ps

module igsfa_ctrl import igsfa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.close && !i_status.drop) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_SEND;
            end
            ST_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.last_word) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.next_word = 1'b1;
                        n_state         = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/igsfa_datapath.sv -----
`timescale 1ns / 1ps

module igsfa_datapath import igsfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_byte,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic [OUT_DW-1:0] o_word,
    output logic              o_last_of_frame
);

    logic [9:0]        r_idle_timeout;
    logic [9:0]        r_max_length;
    logic [7:0]        r_frame_type;
    logic [LEN_W-1:0]  r_len;
    logic [IDLE_W-1:0] r_idle;
    logic              r_all_zero;
    logic [31:0]       r_counter;
    logic [ROW_W-1:0]  r_word;
    logic [63:0]       r_rd;
    logic [63:0]       r_mem [WORD_ROWS];

    logic [LEN_W-1:0]  n_len;
    logic [IDLE_W-1:0] n_idle;
    logic              n_all_zero;
    logic [LEN_W-1:0]  n_limit;
    logic [31:0]       n_counter;
    logic              store_en;
    logic              close_now;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= IDLE_TIMEOUT_RST;
            r_max_length   <= MAX_LENGTH_RST;
            r_frame_type   <= FRAME_TYPE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_wdata;
                REG_MAX_LENGTH:   r_max_length   <= i_cfg_wdata;
                REG_FRAME_TYPE:   r_frame_type   <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Effective length limit: zero acts as one, and the store depth caps it.
    always_comb begin
        if (r_max_length == '0) begin
            n_limit = LEN_W'(1);
        end else if (r_max_length > LEN_W'(FRAME_BYTES)) begin
            n_limit = LEN_W'(FRAME_BYTES);
        end else begin
            n_limit = r_max_length;
        end
    end

    // Frame state update for the item on the input and the close decision.
    always_comb begin
        n_len      = r_len;
        n_idle     = r_idle;
        n_all_zero = r_all_zero;
        store_en   = 1'b0;
        close_now  = 1'b0;
        case (i_kind)
            KIND_BYTE: begin
                if (r_len < LEN_W'(FRAME_BYTES)) begin
                    store_en = 1'b1;
                    n_len    = r_len + LEN_W'(1);
                end
                if (i_byte != 8'h00) begin
                    n_all_zero = 1'b0;
                end
                n_idle    = '0;
                close_now = (n_len >= n_limit);
            end
            KIND_TICK: begin
                if (r_len != '0) begin
                    if (r_idle != '1) begin
                        n_idle = r_idle + IDLE_W'(1);
                    end
                    close_now = (n_idle > {1'b0, r_idle_timeout});
                end
            end
            KIND_FLUSH: begin
                close_now = (r_len != '0);
            end
            default: begin
            end
        endcase
    end

    // Next frame number skips zero on wrap.
    always_comb begin
        n_counter = r_counter + 32'd1;
        if (n_counter == '0) begin
            n_counter = 32'd1;
        end
    end

    // Frame bookkeeping and word pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_idle     <= '0;
            r_all_zero <= 1'b1;
            r_counter  <= '0;
            r_word     <= '0;
        end else if (i_cmd.accept) begin
            if (o_status.close && o_status.drop) begin
                r_len      <= '0;
                r_idle     <= '0;
                r_all_zero <= 1'b1;
            end else begin
                r_len      <= n_len;
                r_idle     <= n_idle;
                r_all_zero <= n_all_zero;
                if (o_status.close) begin
                    r_counter <= n_counter;
                    r_word    <= '0;
                end
            end
        end else if (i_cmd.next_word) begin
            r_word <= r_word + ROW_W'(1);
        end else if (i_cmd.finish) begin
            r_len      <= '0;
            r_idle     <= '0;
            r_all_zero <= 1'b1;
        end
    end

    // Frame store: one byte lane written per received byte, one word read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && store_en) begin
            r_mem[r_len[LANE_W+ROW_W-1:LANE_W]][r_len[LANE_W-1:0]*8 +: 8] <= i_byte;
        end
        if (i_cmd.read) begin
            r_rd <= r_mem[r_word];
        end
    end

    // Word layout of the frame being emitted.
    logic [LEN_W-1:0] len_m1;
    logic [2:0]       last_part;
    logic             last_word;
    logic [3:0]       valid_bytes;
    logic [2:0]       part_no;
    logic [3:0]       part_total;
    logic [6:0]       part_length;
    logic             last_of_part;
    logic [63:0]      data_word;

    always_comb begin
        len_m1       = r_len - LEN_W'(1);
        last_part    = len_m1[CHUNK_SHIFT+2:CHUNK_SHIFT];
        last_word    = (r_word == len_m1[LANE_W+ROW_W-1:LANE_W]);
        valid_bytes  = last_word ? ({1'b0, len_m1[LANE_W-1:0]} + 4'd1) : 4'(WORD_BYTES);
        part_no      = r_word[ROW_W-1:CHUNK_SHIFT-LANE_W];
        part_total   = {1'b0, last_part} + 4'd1;
        part_length  = (part_no == last_part)
                     ? ({1'b0, len_m1[CHUNK_SHIFT-1:0]} + 7'd1) : 7'(CHUNK_BYTES);
        last_of_part = last_word || (r_word[CHUNK_SHIFT-LANE_W-1:0] == '1);
        for (int i = 0; i < WORD_BYTES; i++) begin
            data_word[i*8 +: 8] = (4'(i) < valid_bytes) ? r_rd[i*8 +: 8] : 8'h00;
        end
    end

    // Status fields in declaration order: close, drop, last word.
    assign o_status        = {close_now, n_all_zero, last_word};
    assign o_last_of_frame = last_word;
    assign o_word = {5'b0, last_of_part, part_length, part_total, part_no,
                     r_counter, r_frame_type, valid_bytes, data_word};

endmodule

// ----- hw/rtl/idle_gap_serial_frame_assembler_top.sv -----
`timescale 1ns / 1ps
// Input items take one cycle each while no frame is being emitted.
// A closed frame of L bytes that is not all zero is emitted as ceil(L/8) words, each
// word a frame-store read (ST_READ) and then an output transfer (ST_SEND) that
// waits for m_axis_tready; no item is taken until the last word is sent.
// Reset (synchronous, active low) clears the open frame, the frame counter and
// restores the registers; the frame store itself is not cleared.

module idle_gap_serial_frame_assembler_top import igsfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration writes
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,  // [7:0] data_byte
    input  logic [1:0]        s_axis_tuser,  // [1:0] kind
    // Output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [63:0] data_word, [67:64] valid bytes, [75:68] type_tag,
    // [107:76] frame_number, [110:108] part number, [114:111] part_total,
    // [121:115] part_length, [122] last_of_part, [127:123] zero
    output logic [OUT_DW-1:0] m_axis_tdata,
    output logic              m_axis_tlast   // last_of_frame
);

    t_cmd    cmd;
    t_status status;

    // Sequencing of item intake and word emission.
    igsfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Frame store, counters and word formatting.
    igsfa_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_kind          (s_axis_tuser),
        .i_byte          (s_axis_tdata),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_word          (m_axis_tdata),
        .o_last_of_frame (m_axis_tlast)
    );

endmodule

// ----- verif/tb_idle_gap_serial_frame_assembler_top.sv -----
`timescale 1ns / 1ps

module tb_idle_gap_serial_frame_assembler_top;
    import igsfa_pkg::*;

    localparam int          IDLE_PCT      = 21;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          END_CYCLES    = 20;
    localparam int          MAX_PRINTED   = 100;
    localparam int          IDLE_SAT      = (1 << IDLE_W) - 1;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;
    localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

    // Layout of one output word on m_axis_tdata, highest bits first.
    typedef struct packed {
        logic [4:0]  pad;
        logic        last_of_part;
        logic [6:0]  part_length;
        logic [3:0]  part_total;
        logic [2:0]  part_no;
        logic [31:0] frame_number;
        logic [7:0]  type_tag;
        logic [3:0]  valid_bytes;
        logic [63:0] data_word;
    } t_word;

    typedef struct {
        t_word w;
        logic  eof;
    } t_expected_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_serial_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic              m_axis_tlast;

    idle_gap_serial_frame_assembler_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Pending serial items and the words that the frames closed so far must produce.
    t_serial_item   tx_items[$];
    t_serial_item   tx_head;
    t_expected_word pending_words[$];

    // Shadow copy of the assembler state and its registers.
    logic [7:0]  shadow_store [FRAME_BYTES];
    int unsigned shadow_len;
    int unsigned shadow_idle;
    logic        shadow_all_zero;
    logic [31:0] shadow_frame_no;
    logic [9:0]  reg_idle_timeout;
    logic [9:0]  reg_max_length;
    logic [7:0]  reg_frame_type;

    // Run control and statistics.
    logic        calm = 1'b0;
    logic        hold_on = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_cnt = 0;
    int unsigned n_errors = 0;
    int unsigned n_items_in = 0;
    int unsigned n_words = 0;
    int unsigned n_frames = 0;
    int unsigned n_input_stalls = 0;
    int unsigned n_settings = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic log_mismatch(input string msg);
        if (n_errors < MAX_PRINTED)
            $display("ERROR at %0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            log_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                   n_words, name, got, want));
    endtask

    task automatic reset_shadow();
        shadow_len       = 0;
        shadow_idle      = 0;
        shadow_all_zero  = 1'b1;
        shadow_frame_no  = '0;
        reg_idle_timeout = IDLE_TIMEOUT_RST;
        reg_max_length   = MAX_LENGTH_RST;
        reg_frame_type   = FRAME_TYPE_RST;
    endtask

    // Close the open frame: an all-zero frame vanishes, any other becomes words.
    task automatic close_frame_words();
        int unsigned    parts;
        int unsigned    part;
        int unsigned    pos;
        int unsigned    plen;
        int unsigned    done;
        int unsigned    cnt;
        int unsigned    b;
        t_expected_word e;
        if (shadow_len != 0 && !shadow_all_zero) begin
            shadow_frame_no = shadow_frame_no + 32'd1;
            if (shadow_frame_no == '0)
                shadow_frame_no = 32'd1;
            n_frames++;
            parts = (shadow_len + CHUNK_BYTES - 1) / CHUNK_BYTES;
            pos = 0;
            for (part = 0; part < parts; part++) begin
                plen = shadow_len - pos;
                if (plen > CHUNK_BYTES)
                    plen = CHUNK_BYTES;
                done = 0;
                while (done < plen) begin
                    cnt = plen - done;
                    if (cnt > WORD_BYTES)
                        cnt = WORD_BYTES;
                    e.w = '0;
                    for (b = 0; b < cnt; b++)
                        e.w.data_word[8*b +: 8] = shadow_store[pos + done + b];
                    done += cnt;
                    e.w.valid_bytes  = 4'(cnt);
                    e.w.type_tag     = reg_frame_type;
                    e.w.frame_number = shadow_frame_no;
                    e.w.part_no      = 3'(part);
                    e.w.part_total   = 4'(parts);
                    e.w.part_length  = 7'(plen);
                    e.w.last_of_part = (done == plen);
                    e.eof            = (done == plen) && (part + 1 == parts);
                    pending_words.push_back(e);
                end
                pos += plen;
            end
        end
        shadow_len      = 0;
        shadow_idle     = 0;
        shadow_all_zero = 1'b1;
    endtask

    // Advance the shadow state by one accepted serial item.
    task automatic track_item(input logic [1:0] kind, input logic [7:0] data);
        int unsigned limit;
        limit = (reg_max_length == 0) ? 1 :
                ((reg_max_length > FRAME_BYTES) ? FRAME_BYTES : reg_max_length);
        case (kind)
            KIND_BYTE: begin
                if (shadow_len < FRAME_BYTES) begin
                    shadow_store[shadow_len] = data;
                    shadow_len++;
                end
                if (data != 8'h00)
                    shadow_all_zero = 1'b0;
                shadow_idle = 0;
                if (shadow_len >= limit)
                    close_frame_words();
            end
            KIND_TICK: begin
                if (shadow_len != 0) begin
                    if (shadow_idle < IDLE_SAT)
                        shadow_idle++;
                    if (shadow_idle > reg_idle_timeout)
                        close_frame_words();
                end
            end
            KIND_FLUSH: begin
                if (shadow_len != 0)
                    close_frame_words();
            end
            default: ;
        endcase
    endtask

    task automatic add_item(input logic [1:0] kind, input logic [7:0] data);
        t_serial_item it;
        it.kind = kind;
        it.data = data;
        tx_items.push_back(it);
    endtask

    // Mostly whole frames with random content and a closing event, some noise,
    // and a few nonzero bytes at the end so that a frame is left open.
    task automatic queue_traffic(input int n_items);
        int added;
        int len;
        int pick;
        bit zeros;
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 130)
                                                  : $urandom_range(1, 20);
                zeros = ($urandom_range(0, 9) == 0);
                repeat (len)
                    add_item(KIND_BYTE, (zeros || $urandom_range(0, 6) == 0) ? 8'h00
                                                                        : 8'($urandom()));
                added += len;
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    add_item(KIND_FLUSH, 8'($urandom()));
                    added++;
                end else if (pick < 8 && reg_idle_timeout <= 20) begin
                    repeat (reg_idle_timeout + 1)
                        add_item(KIND_TICK, 8'($urandom()));
                    added += reg_idle_timeout + 1;
                end else if (pick < 8) begin
                    repeat (3)
                        add_item(KIND_TICK, 8'($urandom()));
                    add_item(KIND_FLUSH, 8'($urandom()));
                    added += 4;
                end
            end else begin
                pick = $urandom_range(0, 2);
                case (pick)
                    0: add_item(KIND_TICK, 8'($urandom()));
                    1: add_item(KIND_FLUSH, 8'($urandom()));
                    default: add_item(KIND_UNUSED, 8'($urandom()));
                endcase
                added++;
            end
        end
        repeat ($urandom_range(3, 6))
            add_item(KIND_BYTE, 8'($urandom_range(1, 255)));
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_IDLE_TIMEOUT: reg_idle_timeout = val;
            REG_MAX_LENGTH:   reg_max_length   = val;
            REG_FRAME_TYPE:   reg_frame_type   = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [9:0] idle, input logic [9:0] max_len,
                                 input logic [7:0] ftype);
        write_reg(REG_IDLE_TIMEOUT, idle);
        write_reg(REG_MAX_LENGTH, max_len);
        write_reg(REG_FRAME_TYPE, {2'b00, ftype});
        n_settings++;
    endtask

    // Wait until every item has gone in and every expected word has come out.
    task automatic drain(input int settle);
        while (tx_items.size() != 0 || s_axis_tvalid || pending_words.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Sender: offer the queued items, idling at random unless the run is calm.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_item(s_axis_tuser, s_axis_tdata);
                n_items_in++;
            end
            if (s_axis_tvalid && !s_axis_tready)
                n_input_stalls++;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    tx_head = tx_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= tx_head.kind;
                    s_axis_tdata  <= tx_head.data;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off: once requested, block the output for a fixed stretch.
    always @(posedge i_clk) begin
        if (hold_on && !hold_done) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
    end

    // Receiver: check each output transfer against the oldest expected word.
    always @(posedge i_clk) begin
        t_word          got;
        t_expected_word want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_words.size() == 0) begin
                    log_mismatch($sformatf("unexpected word %0h", m_axis_tdata));
                end else begin
                    want = pending_words.pop_front();
                    check_field("data_word", got.data_word, want.w.data_word);
                    check_field("valid bytes", got.valid_bytes, want.w.valid_bytes);
                    check_field("type_tag", got.type_tag, want.w.type_tag);
                    check_field("frame_number", got.frame_number, want.w.frame_number);
                    check_field("part number", got.part_no, want.w.part_no);
                    check_field("part_total", got.part_total, want.w.part_total);
                    check_field("part_length", got.part_length, want.w.part_length);
                    check_field("last_of_part", got.last_of_part, want.w.last_of_part);
                    check_field("last_of_frame", m_axis_tlast, want.eof);
                end
                n_words++;
            end
            m_axis_tready <= !(hold_on && !hold_done) &&
                             (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus and run sequence.
    initial begin
        reset_shadow();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-frame events, dropped zero frame, timeout and flush closes.
        add_item(KIND_TICK, 8'h00);
        add_item(KIND_FLUSH, 8'hFF);
        add_item(KIND_UNUSED, 8'hFF);
        add_item(KIND_BYTE, 8'h00);
        add_item(KIND_BYTE, 8'h00);
        add_item(KIND_FLUSH, 8'h00);
        add_item(KIND_BYTE, 8'hFF);
        add_item(KIND_BYTE, 8'h00);
        add_item(KIND_BYTE, 8'hA5);
        add_item(KIND_UNUSED, 8'h00);
        repeat (IDLE_TIMEOUT_RST + 1)
            add_item(KIND_TICK, 8'hFF);
        add_item(KIND_BYTE, 8'h80);
        add_item(KIND_BYTE, 8'h01);
        add_item(KIND_FLUSH, 8'h5A);
        drain(SETTLE_CYCLES);

        // Random traffic with no idling on either side.
        calm <= 1'b1;
        set_registers(10'd5, 10'd200, 8'hC3);
        queue_traffic(30);
        drain(SETTLE_CYCLES);
        calm <= 1'b0;

        // Length limit of zero behaves as one, lowered under the open frame;
        // an unmapped register index is written and must change nothing.
        set_registers(10'd0, 10'd0, 8'hFF);
        write_reg(REG_UNUSED, 10'h3FF);
        queue_traffic(20);
        drain(SETTLE_CYCLES);

        // Receiver holds off while frames keep closing, so the input backs up.
        set_registers(10'd3, 10'd16, 8'h33);
        hold_on <= 1'b1;
        repeat (20)
            add_item(KIND_BYTE, 8'($urandom_range(1, 255)));
        queue_traffic(30);
        drain(SETTLE_CYCLES);

        // Over-range length limit acts as the store depth; a frame split into a
        // full and a short part, then a few ticks under the longest timeout.
        set_registers(10'h3FF, 10'h3FF, 8'h00);
        repeat (100)
            add_item(KIND_BYTE, 8'($urandom()));
        add_item(KIND_FLUSH, 8'h00);
        repeat (3)
            add_item(KIND_BYTE, 8'($urandom_range(1, 255)));
        repeat (5)
            add_item(KIND_TICK, 8'($urandom()));
        add_item(KIND_FLUSH, 8'h00);
        drain(SETTLE_CYCLES);

        set_registers(10'd10, 10'd9, 8'h5A);
        queue_traffic(20);
        drain(SETTLE_CYCLES);

        // Limit one byte past a whole part, so frames that reach it split into a full and a short part.
        set_registers(10'd2, 10'd65, 8'h12);
        queue_traffic(20);
        drain(SETTLE_CYCLES);

        set_registers(10'd1, 10'd512, 8'hA5);
        queue_traffic(20);
        drain(END_CYCLES);

        if (pending_words.size() != 0)
            log_mismatch($sformatf("%0d expected words never arrived", pending_words.size()));
        $display("Run covered %0d input transfers and %0d output words in %0d frames",
                 n_items_in, n_words, n_frames);
        $display("over %0d register settings; input held back for %0d cycles",
                 n_settings, n_input_stalls);
        if (n_errors == 0) begin
            $display("PASS idle_gap_serial_frame_assembler_top");
        end else begin
            $display("FAIL idle_gap_serial_frame_assembler_top");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #1000000;
        $display("FAIL idle_gap_serial_frame_assembler_top");
        $finish;
    end

endmodule

// ----- idle_gap_serial_frame_assembler_top.f -----
hw/rtl/igsfa_pkg.sv
hw/rtl/igsfa_ctrl.sv
hw/rtl/igsfa_datapath.sv
hw/rtl/idle_gap_serial_frame_assembler_top.sv
verif/tb_idle_gap_serial_frame_assembler_top.sv
